>>> rtl/bpdt_pkg.sv
// ----------------------------------------------------------------------------
// bpdt_pkg: shared types and constants
// Register indexes, sequencer states and the lane record of the shared
// restoring divider used by the binomial prime divisibility test.
// ----------------------------------------------------------------------------
`default_nettype none

package bpdt_pkg;

  // Fixed field widths
  localparam int unsigned BaseW  = 16;
  localparam int unsigned FieldW = 32;
  localparam int unsigned CfgIdxW = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PRIME_BASE  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_UPPER_VALUE = 1'b1;

  // Reset values of the configuration registers
  localparam logic [BaseW-1:0]  PRIME_BASE_RST  = 16'd2;
  localparam logic [FieldW-1:0] UPPER_VALUE_RST = 32'd0;
  localparam logic [BaseW-1:0]  MIN_BASE        = 16'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK
  } state_e;

  // One lane of the divider: running remainder plus one bit
  // (dividend bit going in, quotient bit coming out)
  typedef struct packed {
    logic [BaseW-1:0] rem;
    logic             dbit;
  } lane_t;

endpackage

`default_nettype wire

>>> rtl/binomial_prime_divisibility_test.sv
// ----------------------------------------------------------------------------
// binomial_prime_divisibility_test: Lucas-theorem divisibility check
// Reports whether the configured prime p divides C(m, t) for each t.
// ----------------------------------------------------------------------------
// Usage:
//   Write prime_base (index 0) and upper_value m (index 1) through the cfg
//   port while the block is idle. Each transfer on the slave stream carries
//   one lower index t; the master stream returns one transfer per item whose
//   bit 0 is 1 when p divides C(m, t).
//   m and t are cut to VALUE_WIDTH bits (at most 32) and divided by p
//   together, least significant digit first, on one shared two-lane
//   restoring divider that retires one dividend bit per cycle. Digit k
//   (k = 0, 1, ...) has a dividend of W - k bits and ends in a compare
//   step, W = min(VALUE_WIDTH, 32), as every quotient is one bit shorter
//   than its dividend. An item ends at the first digit of t above the
//   digit of m, or once both quotients reach zero.
//   The block takes one item at a time; s_axis_tready is low while it
//   works. A result waits in an output register; the next item may be
//   accepted meanwhile, and the sequencer holds its final compare step until the
//   receiver takes the pending result.
//   Reset sets p = 2, m = 0 and empties the block. A base below 2 acts as 2.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_prime_divisibility_test #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [bpdt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpdt_pkg::FieldW-1:0]   cfg_wdata_i,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [bpdt_pkg::FieldW-1:0]   s_axis_tdata_i,  // [31:0] lower_index
  // Result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [7:0]                    m_axis_tdata_o   // [0] divisible, [7:1] zero
);

  localparam int unsigned EffW =
      (VALUE_WIDTH < bpdt_pkg::FieldW) ? VALUE_WIDTH : bpdt_pkg::FieldW;
  localparam int unsigned LenW = $clog2(EffW + 1);
  localparam int unsigned IdxW = $clog2(EffW);

  // Configuration registers
  logic [bpdt_pkg::BaseW-1:0]  prime_base_q;
  logic [bpdt_pkg::FieldW-1:0] upper_value_q;
  logic [bpdt_pkg::BaseW-1:0]  divisor;

  // Sequencer and datapath registers
  bpdt_pkg::state_e           state_q, state_d;
  logic [EffW-1:0]            top_q, top_d;
  logic [EffW-1:0]            bot_q, bot_d;
  logic [bpdt_pkg::BaseW-1:0] rem_t_q, rem_t_d;
  logic [bpdt_pkg::BaseW-1:0] rem_b_q, rem_b_d;
  logic [LenW-1:0]            len_q, len_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  logic                       divisible_q, divisible_d;

  // Control decoded from the state
  logic accept;
  logic digit_hit;
  logic values_zero;
  logic finish;
  logic out_free;
  logic do_div;
  logic do_finish;
  logic do_next;

  bpdt_pkg::lane_t lane_t_in, lane_b_in, lane_t_out, lane_b_out;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_base_q  <= bpdt_pkg::PRIME_BASE_RST;
      upper_value_q <= bpdt_pkg::UPPER_VALUE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpdt_pkg::REG_PRIME_BASE:  prime_base_q  <= cfg_wdata_i[bpdt_pkg::BaseW-1:0];
        bpdt_pkg::REG_UPPER_VALUE: upper_value_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp the base to at least two
  assign divisor = (prime_base_q < bpdt_pkg::MIN_BASE) ? bpdt_pkg::MIN_BASE : prime_base_q;

  // Shared divider
  assign lane_t_in = '{rem: rem_t_q, dbit: top_q[idx_q]};
  assign lane_b_in = '{rem: rem_b_q, dbit: bot_q[idx_q]};

  bpdt_divstep u_divstep (
    .divisor_i (divisor),
    .top_i     (lane_t_in),
    .bot_i     (lane_b_in),
    .top_o     (lane_t_out),
    .bot_o     (lane_b_out)
  );

  // Digit compare and end test
  assign digit_hit   = rem_b_q > rem_t_q;
  assign values_zero = (top_q == '0) && (bot_q == '0);
  assign finish      = digit_hit || values_zero;
  assign out_free    = !out_valid_q || m_axis_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpdt_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = bpdt_pkg::ST_DIV;
        end
      end
      bpdt_pkg::ST_DIV: begin
        if (idx_q == '0) begin
          state_d = bpdt_pkg::ST_CHECK;
        end
      end
      bpdt_pkg::ST_CHECK: begin
        if (!finish) begin
          state_d = bpdt_pkg::ST_DIV;
        end else if (out_free) begin
          state_d = bpdt_pkg::ST_IDLE;
        end
      end
      default: state_d = bpdt_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    do_div          = 1'b0;
    do_finish       = 1'b0;
    do_next         = 1'b0;
    unique case (state_q)
      bpdt_pkg::ST_IDLE:  s_axis_tready_o = 1'b1;
      bpdt_pkg::ST_DIV:   do_div          = 1'b1;
      bpdt_pkg::ST_CHECK: begin
        do_next   = !finish;
        do_finish = finish && out_free;
      end
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  // Datapath next values
  always_comb begin
    top_d   = top_q;
    bot_d   = bot_q;
    rem_t_d = rem_t_q;
    rem_b_d = rem_b_q;
    len_d   = len_q;
    idx_d   = idx_q;
    if (accept) begin
      top_d   = upper_value_q[EffW-1:0];
      bot_d   = s_axis_tdata_i[EffW-1:0];
      rem_t_d = '0;
      rem_b_d = '0;
      len_d   = LenW'(EffW);
      idx_d   = IdxW'(EffW - 1);
    end else if (do_div) begin
      // Quotient bit replaces the dividend bit just consumed
      top_d[idx_q] = lane_t_out.dbit;
      bot_d[idx_q] = lane_b_out.dbit;
      rem_t_d      = lane_t_out.rem;
      rem_b_d      = lane_b_out.rem;
      idx_d        = idx_q - IdxW'(1);
    end else if (do_next) begin
      // Quotients are one bit shorter: start the next digit there
      rem_t_d = '0;
      rem_b_d = '0;
      len_d   = len_q - LenW'(1);
      idx_d   = IdxW'(len_q - LenW'(2));
    end
  end

  // Result register
  always_comb begin
    out_valid_d = out_valid_q;
    divisible_d = divisible_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (do_finish) begin
      out_valid_d = 1'b1;
      divisible_d = digit_hit;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpdt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    top_q       <= top_d;
    bot_q       <= bot_d;
    rem_t_q     <= rem_t_d;
    rem_b_q     <= rem_b_d;
    len_q       <= len_d;
    idx_q       <= idx_d;
    divisible_q <= divisible_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'b0, divisible_q};

endmodule

`default_nettype wire

>>> rtl/bpdt_divstep.sv
// ----------------------------------------------------------------------------
// bpdt_divstep: one restoring division step on two lanes
// Shifts one dividend bit into each lane's remainder, compares against the
// shared divisor and subtracts on a fit, giving one quotient bit per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdt_divstep (
  input  logic [bpdt_pkg::BaseW-1:0] divisor_i,
  input  bpdt_pkg::lane_t            top_i,
  input  bpdt_pkg::lane_t            bot_i,
  output bpdt_pkg::lane_t            top_o,
  output bpdt_pkg::lane_t            bot_o
);

  logic [bpdt_pkg::BaseW:0] trial_top;
  logic [bpdt_pkg::BaseW:0] trial_bot;
  logic [bpdt_pkg::BaseW:0] dvs_ext;
  logic [bpdt_pkg::BaseW:0] diff_top;
  logic [bpdt_pkg::BaseW:0] diff_bot;

  // Shift in the next dividend bit
  assign trial_top = {top_i.rem, top_i.dbit};
  assign trial_bot = {bot_i.rem, bot_i.dbit};
  assign dvs_ext   = {1'b0, divisor_i};
  assign diff_top  = trial_top - dvs_ext;
  assign diff_bot  = trial_bot - dvs_ext;

  // Subtract where the divisor fits; remainder stays below the divisor
  always_comb begin
    if (trial_top >= dvs_ext) begin
      top_o.rem  = diff_top[bpdt_pkg::BaseW-1:0];
      top_o.dbit = 1'b1;
    end else begin
      top_o.rem  = trial_top[bpdt_pkg::BaseW-1:0];
      top_o.dbit = 1'b0;
    end
    if (trial_bot >= dvs_ext) begin
      bot_o.rem  = diff_bot[bpdt_pkg::BaseW-1:0];
      bot_o.dbit = 1'b1;
    end else begin
      bot_o.rem  = trial_bot[bpdt_pkg::BaseW-1:0];
      bot_o.dbit = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bpdt_checker.sv
// ----------------------------------------------------------------------------
// bpdt_checker: port-level checks for the divisibility test
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module bpdt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result dropped or changed");

  // Drop ready in the cycle after each input transfer
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while previous item in work");

  // A new result may only rise while ready is low or as ready rises
  a_result_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !s_axis_tready_o || $past(!s_axis_tready_o))
    else $error("result without work");

  // Keep the pad bits of the result zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:1] == 7'b0)
    else $error("result pad bits set");

endmodule

bind binomial_prime_divisibility_test bpdt_checker u_bpdt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
